@@ sv/sss_pkg.sv @@
package sss_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned          PATTERN_MAX_DEF = 16;
	localparam longint unsigned      TEXT_MAX_DEF    = 65536;

	// Fixed field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 5;
	localparam int unsigned START_W  = 16;
	localparam int unsigned CFG_W    = 64;
	localparam int unsigned ADDR_W   = 6;
	localparam int unsigned PAT_BYTES = 16;

	// Register indexes (byte address = 8 * index)
	localparam logic [2:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [2:0] REG_PATTERN_LOW    = 3'd1;
	localparam logic [2:0] REG_PATTERN_HIGH   = 3'd2;
	localparam logic [2:0] REG_IGNORE_CASE    = 3'd3;
	localparam logic [2:0] REG_FROM_END       = 3'd4;

	// Result word, found in bit 0
	typedef struct packed {
		logic               overflow;
		logic [START_W-1:0] match_start;
		logic               found;
	} result_t;

	localparam int unsigned OUT_DATA_W = ((($bits(result_t)) + 7) / 8) * 8;

	// ASCII upper-case letters fold to lower case when enabled
	function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
	                                                input logic             ic);
		logic [BYTE_W-1:0] r;
		r = c;
		if (ic && c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

@@ sv/substring_search_first_or_last.sv @@
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata[7:0] text_byte, s_tlast is_last
// m_*       out  m_tvalid/m_tready   m_tdata: found, match_start, overflow
// apb       in   psel/penable/pwrite  paddr = 8*index, 64-bit pwdata/prdata
//
// One text word per cycle sustained. A word sits in the registered input stage,
// where the window shift, the parallel pattern compare and the state update
// happen; a last word loads the result register, so its result shows in the
// cycle after the stage. Only a last word waits when the result register is
// still full and m_tready is low; other words never stall.
// arst_n clears control, configuration, counters and the window to zero; byte_s1, last_s1 and res_q are not reset.
module substring_search_first_or_last #(
	parameter int unsigned     PATTERN_MAX = sss_pkg::PATTERN_MAX_DEF,
	parameter longint unsigned TEXT_MAX    = sss_pkg::TEXT_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// text stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] text_byte
	input  logic                          s_tlast,   // is_last
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sss_pkg::OUT_DATA_W-1:0] m_tdata,  // [0] found, [16:1] match_start,
	                                                  // [17] overflow, rest zero
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sss_pkg::ADDR_W-1:0]    paddr,
	input  logic [sss_pkg::CFG_W-1:0]     pwdata,
	output logic [sss_pkg::CFG_W-1:0]     prdata,
	output logic                          pready
);
	import sss_pkg::*;

	localparam int unsigned CNT_W = $clog2(TEXT_MAX + 1);
	localparam int unsigned SW    = (CNT_W > START_W) ? CNT_W : START_W;
	localparam int unsigned IW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	// ---------------- configuration registers ----------------
	logic [LEN_W-1:0] pat_len_q;
	logic [CFG_W-1:0] pat_low_q;
	logic [CFG_W-1:0] pat_high_q;
	logic             ignore_case_q;
	logic             from_end_q;
	logic [2:0]       reg_idx;
	logic             cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q     <= '0;
			pat_low_q     <= '0;
			pat_high_q    <= '0;
			ignore_case_q <= 1'b0;
			from_end_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PATTERN_LENGTH: pat_len_q     <= pwdata[LEN_W-1:0];
				REG_PATTERN_LOW:    pat_low_q     <= pwdata;
				REG_PATTERN_HIGH:   pat_high_q    <= pwdata;
				REG_IGNORE_CASE:    ignore_case_q <= pwdata[0];
				REG_FROM_END:       from_end_q    <= pwdata[0];
				default: ;  // unmapped, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PATTERN_LENGTH: prdata = {{(CFG_W-LEN_W){1'b0}}, pat_len_q};
			REG_PATTERN_LOW:    prdata = pat_low_q;
			REG_PATTERN_HIGH:   prdata = pat_high_q;
			REG_IGNORE_CASE:    prdata = {{(CFG_W-1){1'b0}}, ignore_case_q};
			REG_FROM_END:       prdata = {{(CFG_W-1){1'b0}}, from_end_q};
			default:            prdata = '0;
		endcase
	end

	// ---------------- input stage ----------------
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              adv;        // stage word is processed this cycle

	logic              out_valid_q;
	result_t           res_q;

	// only a last word needs room in the result register
	assign adv      = valid_s1 && !(last_s1 && out_valid_q && !m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// ---------------- text state ----------------
	logic [BYTE_W-1:0]  win_q [PATTERN_MAX];  // index 0 = newest
	logic [CNT_W-1:0]   bytes_seen_q;
	logic               match_seen_q;
	logic [START_W-1:0] chosen_start_q;
	logic               overflowed_q;

	logic [BYTE_W-1:0]  win_nx [PATTERN_MAX];
	logic [CNT_W-1:0]   cnt_nx;
	logic               full;
	logic               len_ok;
	logic [PATTERN_MAX-1:0] ok;
	logic               hit;
	logic [SW-1:0]      start_w;
	logic [8*PAT_BYTES-1:0] pat_all;
	logic               match_nx;
	logic [START_W-1:0] chosen_nx;
	logic               ovf_nx;
	result_t            res_nx;

	assign pat_all = {pat_high_q, pat_low_q};
	assign full    = (bytes_seen_q >= CNT_W'(TEXT_MAX));
	assign cnt_nx  = bytes_seen_q + CNT_W'(1);

	always_comb begin
		win_nx[0] = byte_s1;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_nx[k] = win_q[k-1];
		end
	end

	assign len_ok = (pat_len_q != '0)
	             && ({27'd0, pat_len_q} <= 32'(PATTERN_MAX))
	             && (SW'(cnt_nx) >= SW'(pat_len_q));

	// pattern byte i lines up with window slot len-1-i
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			logic [LEN_W-1:0] j;
			j = pat_len_q - LEN_W'(1) - LEN_W'(i);
			ok[i] = (LEN_W'(i) >= pat_len_q)
			     || (fold_byte(win_nx[j[IW-1:0]], ignore_case_q)
			         == fold_byte(pat_all[8*i +: 8], ignore_case_q));
		end
	end

	assign hit     = !full && len_ok && (&ok);
	assign start_w = SW'(cnt_nx) - SW'(pat_len_q);

	always_comb begin
		match_nx  = match_seen_q;
		chosen_nx = chosen_start_q;
		ovf_nx    = overflowed_q || full;
		if (hit) begin
			match_nx = 1'b1;
			if (from_end_q || !match_seen_q) begin
				chosen_nx = start_w[START_W-1:0];
			end
		end
		res_nx.found       = match_nx;
		res_nx.match_start = match_nx ? chosen_nx : '0;
		res_nx.overflow    = ovf_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= '0;
			end
			bytes_seen_q   <= '0;
			match_seen_q   <= 1'b0;
			chosen_start_q <= '0;
			overflowed_q   <= 1'b0;
		end else if (adv) begin
			if (!full) begin
				for (int k = 0; k < PATTERN_MAX; k++) begin
					win_q[k] <= win_nx[k];
				end
			end
			if (last_s1) begin
				// text done: start over for the next one
				bytes_seen_q   <= '0;
				match_seen_q   <= 1'b0;
				chosen_start_q <= '0;
				overflowed_q   <= 1'b0;
			end else begin
				if (!full) begin
					bytes_seen_q <= cnt_nx;
				end
				match_seen_q   <= match_nx;
				chosen_start_q <= chosen_nx;
				overflowed_q   <= ovf_nx;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, res_q};

	// ---------------- checks ----------------
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> m_tvalid)
		else $error("last word did not load a result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= CNT_W'(TEXT_MAX))
		else $error("byte count past limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> bytes_seen_q == '0 && !match_seen_q && !overflowed_q)
		else $error("text state not cleared after last word");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_q.found |-> res_q.match_start == '0)
		else $error("offset nonzero without a match");

	a_no_match_without_count: assert property (@(posedge clk) disable iff (!arst_n)
		match_seen_q |-> bytes_seen_q != '0)
		else $error("match recorded with empty text");

endmodule
